// ----- rtl/rtr_pkg.sv -----
// shared types, op codes and tables for the four-way router with undo history
package rtr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int HISTORY_DEPTH = 128;
  localparam int DEPTH_BITS    = 8;
  localparam int OP_BITS       = 4;
  localparam int PICK_BITS     = 5;
  localparam int MAP_BITS      = 8;
  localparam int PERM_COUNT    = 24;

  localparam logic [MAP_BITS-1:0] IDENTITY_MAP = 8'hE4;

  typedef enum logic [OP_BITS-1:0] {
    OP_NONE     = 4'd0,
    OP_ROT_DOWN = 4'd1,
    OP_ROT_UP   = 4'd2,
    OP_RESET    = 4'd3,
    OP_SWAP_AB  = 4'd4,
    OP_SWAP_CD  = 4'd5,
    OP_SWAP_BC  = 4'd6,
    OP_SWAP_AD  = 4'd7,
    OP_SWAP_AC  = 4'd8,
    OP_SWAP_BD  = 4'd9,
    OP_RANDOM   = 4'd10,
    OP_UNDO     = 4'd11,
    OP_REDO     = 4'd12
  } op_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [PICK_BITS-1:0] random_pick;
    sample_t              sample_in_a;
    sample_t              sample_in_b;
    sample_t              sample_in_c;
    sample_t              sample_in_d;
    logic                 linked_a;
    logic                 linked_b;
    logic                 linked_c;
    logic                 linked_d;
  } in_t;

  typedef struct packed {
    sample_t               sample_out_a;
    sample_t               sample_out_b;
    sample_t               sample_out_c;
    sample_t               sample_out_d;
    logic [1:0]            source_of_a;
    logic [1:0]            source_of_b;
    logic [1:0]            source_of_c;
    logic [1:0]            source_of_d;
    logic [DEPTH_BITS-1:0] undo_depth;
    logic [DEPTH_BITS-1:0] redo_depth;
  } out_t;

  // history status handed from the history unit to the map stage
  typedef struct packed {
    logic                  swap;
    logic [DEPTH_BITS-1:0] undo_depth;
    logic [DEPTH_BITS-1:0] redo_depth;
  } hist_info_t;

  // lexicographic permutations of {0,1,2,3}, output a in the low bits
  localparam logic [MAP_BITS-1:0] PERM_TABLE [PERM_COUNT] = '{
    8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
    8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
    8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
    8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
  };

  function automatic logic [MAP_BITS-1:0] perm_map(input logic [PICK_BITS-1:0] pick);
    logic [PICK_BITS-1:0] idx;
    idx = (pick >= PICK_BITS'(PERM_COUNT)) ? pick - PICK_BITS'(PERM_COUNT) : pick;
    return PERM_TABLE[idx];
  endfunction

endpackage

// ----- rtl/four_way_router_with_undo_history.sv -----
// top level: input capture, history read-modify-write stage and output register
//
//  channel | signals                    | direction | payload
//  in      | in_valid, in_ready, in_data | into      | rtr_pkg::in_t
//  out     | out_valid, out_ready, out_data | out of | rtr_pkg::out_t
//
// one transfer per cycle in each direction when out_ready stays high
// result path: the history memory is read as the input is captured, then the map update is registered at the output
// back-to-back undo/redo on the same entry is served by forwarding the pending write
// reset is synchronous; the history memory needs no clearing pass
// a stalled output holds one result and one item in flight, then in_ready drops
module four_way_router_with_undo_history #(
  parameter int HISTORY_DEPTH = rtr_pkg::HISTORY_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rtr_pkg::out_t out_data
);

  logic                s1_valid_r;
  rtr_pkg::in_t        s1_data_r;
  logic                out_valid_r;
  rtr_pkg::out_t       out_data_r;
  rtr_pkg::out_t       out_data_nxt;

  logic                in_xfer;
  logic                s1_adv;
  logic                out_free;

  rtr_pkg::hist_info_t          info;
  logic [rtr_pkg::MAP_BITS-1:0] rd_map;
  logic [rtr_pkg::MAP_BITS-1:0] route_map;
  logic [rtr_pkg::MAP_BITS-1:0] map_nxt;
  rtr_pkg::sample_t             held_nxt [4];

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  rtr_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (in_xfer),
    .operation (in_data.operation),
    .commit    (s1_adv),
    .wr_map    (route_map),
    .info      (info),
    .rd_map    (rd_map)
  );

  rtr_map_unit u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (s1_adv),
    .item      (s1_data_r),
    .info      (info),
    .rd_map    (rd_map),
    .route_map (route_map),
    .map_nxt   (map_nxt),
    .held_nxt  (held_nxt)
  );

  always_comb begin
    out_data_nxt.sample_out_a = held_nxt[0];
    out_data_nxt.sample_out_b = held_nxt[1];
    out_data_nxt.sample_out_c = held_nxt[2];
    out_data_nxt.sample_out_d = held_nxt[3];
    out_data_nxt.source_of_a  = map_nxt[1:0];
    out_data_nxt.source_of_b  = map_nxt[3:2];
    out_data_nxt.source_of_c  = map_nxt[5:4];
    out_data_nxt.source_of_d  = map_nxt[7:6];
    out_data_nxt.undo_depth   = info.undo_depth;
    out_data_nxt.redo_depth   = info.redo_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item produced no result");

  a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item lost before the map stage");

endmodule

// ----- rtl/rtr_history.sv -----
// undo/redo counters, ring addressing and the history memory with write forwarding
module rtr_history #(
  parameter int HISTORY_DEPTH = rtr_pkg::HISTORY_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic [rtr_pkg::OP_BITS-1:0]   operation,
  input  logic                          commit,
  input  logic [rtr_pkg::MAP_BITS-1:0]  wr_map,
  output rtr_pkg::hist_info_t           info,
  output logic [rtr_pkg::MAP_BITS-1:0]  rd_map
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

  logic [rtr_pkg::MAP_BITS-1:0] mem [HISTORY_DEPTH];

  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] undo_cnt_r, undo_cnt_nxt;
  logic [CW-1:0] redo_cnt_r, redo_cnt_nxt;

  logic [AW-1:0] addr_r, addr_nxt;
  logic          edit_r, edit_nxt;
  logic          swap_r, swap_nxt;
  logic [rtr_pkg::MAP_BITS-1:0] rdata_r;
  logic [rtr_pkg::MAP_BITS-1:0] fwd_data_r;
  logic          fwd_hit_r;

  logic          wr_en;
  logic          is_edit;
  logic [AW-1:0] pos_top;
  logic [AW-1:0] pos_next;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(HISTORY_DEPTH)) begin
      sum = sum - (CW+1)'(HISTORY_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign is_edit  = (operation >= rtr_pkg::OP_BITS'(rtr_pkg::OP_ROT_DOWN)) &&
                    (operation <= rtr_pkg::OP_BITS'(rtr_pkg::OP_RANDOM));
  assign pos_top  = ring_pos(base_r, undo_cnt_r - CW'(1));
  assign pos_next = ring_pos(base_r, undo_cnt_r);
  assign wr_en    = commit && (edit_r || swap_r);

  always_comb begin
    base_nxt     = base_r;
    undo_cnt_nxt = undo_cnt_r;
    redo_cnt_nxt = redo_cnt_r;
    addr_nxt     = pos_next;
    edit_nxt     = 1'b0;
    swap_nxt     = 1'b0;
    if (is_edit) begin
      edit_nxt     = 1'b1;
      redo_cnt_nxt = '0;
      if (undo_cnt_r >= DEPTH_C) begin
        addr_nxt = base_r;
        base_nxt = (base_r == LAST_POS) ? '0 : base_r + AW'(1);
      end else begin
        addr_nxt     = pos_next;
        undo_cnt_nxt = undo_cnt_r + CW'(1);
      end
    end else if (operation == rtr_pkg::OP_BITS'(rtr_pkg::OP_UNDO)) begin
      if (undo_cnt_r != '0) begin
        swap_nxt     = 1'b1;
        addr_nxt     = pos_top;
        undo_cnt_nxt = undo_cnt_r - CW'(1);
        redo_cnt_nxt = redo_cnt_r + CW'(1);
      end
    end else if (operation == rtr_pkg::OP_BITS'(rtr_pkg::OP_REDO)) begin
      if (redo_cnt_r != '0) begin
        swap_nxt     = 1'b1;
        addr_nxt     = pos_next;
        undo_cnt_nxt = undo_cnt_r + CW'(1);
        redo_cnt_nxt = redo_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      undo_cnt_r <= '0;
      redo_cnt_r <= '0;
      edit_r     <= 1'b0;
      swap_r     <= 1'b0;
    end else if (issue) begin
      base_r     <= base_nxt;
      undo_cnt_r <= undo_cnt_nxt;
      redo_cnt_r <= redo_cnt_nxt;
      edit_r     <= edit_nxt;
      swap_r     <= swap_nxt;
    end
  end

  // addr and depths of the item in flight
  logic [rtr_pkg::DEPTH_BITS-1:0] undo_depth_r;
  logic [rtr_pkg::DEPTH_BITS-1:0] redo_depth_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      addr_r       <= addr_nxt;
      undo_depth_r <= rtr_pkg::DEPTH_BITS'(undo_cnt_nxt);
      redo_depth_r <= rtr_pkg::DEPTH_BITS'(redo_cnt_nxt);
    end
  end

  // memory port: write back on commit, read on issue
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_map;
    end
    if (issue) begin
      rdata_r    <= mem[addr_nxt];
      fwd_data_r <= wr_map;
    end
  end

  // write of the previous item landing in the same edge as this read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (issue) begin
      fwd_hit_r <= wr_en && (addr_r == addr_nxt);
    end
  end

  assign rd_map          = fwd_hit_r ? fwd_data_r : rdata_r;
  assign info.swap       = swap_r;
  assign info.undo_depth = undo_depth_r;
  assign info.redo_depth = redo_depth_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(undo_cnt_r) + (CW+1)'(redo_cnt_r)) <= (CW+1)'(HISTORY_DEPTH))
    else $error("undo plus redo entries exceed the history size");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= LAST_POS)
    else $error("history base outside the ring");

  a_edit_clears_redo: assert property (@(posedge clk) disable iff (!rst_n)
    issue && is_edit |=> redo_cnt_r == '0)
    else $error("edit left redo entries behind");

  a_base_moves_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    issue && is_edit && (undo_cnt_r < DEPTH_C) |=> $stable(base_r))
    else $error("history base moved without a full undo list");

endmodule

// ----- rtl/rtr_map_unit.sv -----
// route map update and per-output sample routing with hold
module rtr_map_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          commit,
  input  rtr_pkg::in_t                  item,
  input  rtr_pkg::hist_info_t           info,
  input  logic [rtr_pkg::MAP_BITS-1:0]  rd_map,
  output logic [rtr_pkg::MAP_BITS-1:0]  route_map,
  output logic [rtr_pkg::MAP_BITS-1:0]  map_nxt,
  output rtr_pkg::sample_t              held_nxt [4]
);

  logic [rtr_pkg::MAP_BITS-1:0] route_map_r;
  rtr_pkg::sample_t             held_r [4];
  rtr_pkg::sample_t             sample [4];
  logic [3:0]                   linked;

  function automatic logic [rtr_pkg::MAP_BITS-1:0] swap_pair(
      input logic [rtr_pkg::MAP_BITS-1:0] m, input logic [1:0] i, input logic [1:0] j);
    logic [rtr_pkg::MAP_BITS-1:0] r;
    r = m;
    r[2*i +: 2] = m[2*j +: 2];
    r[2*j +: 2] = m[2*i +: 2];
    return r;
  endfunction

  assign sample[0] = item.sample_in_a;
  assign sample[1] = item.sample_in_b;
  assign sample[2] = item.sample_in_c;
  assign sample[3] = item.sample_in_d;
  assign linked    = {item.linked_d, item.linked_c, item.linked_b, item.linked_a};

  always_comb begin
    map_nxt = route_map_r;
    unique case (item.operation) inside
      rtr_pkg::OP_ROT_DOWN: map_nxt = {route_map_r[1:0], route_map_r[7:2]};
      rtr_pkg::OP_ROT_UP:   map_nxt = {route_map_r[5:0], route_map_r[7:6]};
      rtr_pkg::OP_RESET:    map_nxt = rtr_pkg::IDENTITY_MAP;
      rtr_pkg::OP_SWAP_AB:  map_nxt = swap_pair(route_map_r, 2'd0, 2'd1);
      rtr_pkg::OP_SWAP_CD:  map_nxt = swap_pair(route_map_r, 2'd2, 2'd3);
      rtr_pkg::OP_SWAP_BC:  map_nxt = swap_pair(route_map_r, 2'd1, 2'd2);
      rtr_pkg::OP_SWAP_AD:  map_nxt = swap_pair(route_map_r, 2'd0, 2'd3);
      rtr_pkg::OP_SWAP_AC:  map_nxt = swap_pair(route_map_r, 2'd0, 2'd2);
      rtr_pkg::OP_SWAP_BD:  map_nxt = swap_pair(route_map_r, 2'd1, 2'd3);
      rtr_pkg::OP_RANDOM:   map_nxt = rtr_pkg::perm_map(item.random_pick);
      rtr_pkg::OP_UNDO, rtr_pkg::OP_REDO: begin
        if (info.swap) begin
          map_nxt = rd_map;
        end
      end
      default: map_nxt = route_map_r;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      held_nxt[k] = held_r[k];
      if (linked[map_nxt[2*k +: 2]]) begin
        held_nxt[k] = sample[map_nxt[2*k +: 2]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_map_r <= rtr_pkg::IDENTITY_MAP;
      for (int k = 0; k < 4; k++) begin
        held_r[k] <= '0;
      end
    end else if (commit) begin
      route_map_r <= map_nxt;
      for (int k = 0; k < 4; k++) begin
        held_r[k] <= held_nxt[k];
      end
    end
  end

  assign route_map = route_map_r;

  a_map_is_perm: assert property (@(posedge clk) disable iff (!rst_n)
    route_map_r[1:0] != route_map_r[3:2] && route_map_r[1:0] != route_map_r[5:4] &&
    route_map_r[1:0] != route_map_r[7:6] && route_map_r[3:2] != route_map_r[5:4] &&
    route_map_r[3:2] != route_map_r[7:6] && route_map_r[5:4] != route_map_r[7:6])
    else $error("route map is not a permutation");

  a_map_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(route_map_r))
    else $error("route map changed without a commit");

  a_reset_identity: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item.operation == rtr_pkg::OP_RESET |=> route_map_r == rtr_pkg::IDENTITY_MAP)
    else $error("reset operation missed the identity map");

endmodule

// ----- tb/tb_four_way_router_with_undo_history.sv -----
// testbench for the four-way router with undo history: directed and random traffic checked per frame
module tb_four_way_router_with_undo_history;

  localparam int LIMIT       = 1500000;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1850;

  typedef logic [3:0][1:0] route_t;

  class route_tracker;
    route_t           route;
    route_t           history [rtr_pkg::HISTORY_DEPTH];
    int               base;
    int               undo_n;
    int               redo_n;
    rtr_pkg::sample_t held [4];
    rtr_pkg::out_t    frames_due [$];
    int               errors;

    function new();
      route  = route_t'(rtr_pkg::IDENTITY_MAP);
      base   = 0;
      undo_n = 0;
      redo_n = 0;
      errors = 0;
      foreach (held[k]) held[k] = '0;
    endfunction

    function route_t swap_outputs(route_t m, int i, int j);
      route_t r;
      r = m;
      r[i] = m[j];
      r[j] = m[i];
      return r;
    endfunction

    // permutation by lexicographic index, out-of-range picks wrap once
    function route_t load_perm(logic [rtr_pkg::PICK_BITS-1:0] pick);
      int pool [$];
      int fact [4];
      int idx;
      int sel;
      route_t r;
      pool = {0, 1, 2, 3};
      fact = '{6, 2, 1, 1};
      idx = int'(pick);
      if (idx >= rtr_pkg::PERM_COUNT) idx -= rtr_pkg::PERM_COUNT;
      for (int k = 0; k < 4; k++) begin
        sel = idx / fact[k];
        idx = idx % fact[k];
        r[k] = 2'(pool[sel]);
        pool.delete(sel);
      end
      return r;
    endfunction

    function void save_edit();
      if (undo_n >= rtr_pkg::HISTORY_DEPTH) begin
        history[base] = route;
        base = (base + 1) % rtr_pkg::HISTORY_DEPTH;
      end else begin
        history[(base + undo_n) % rtr_pkg::HISTORY_DEPTH] = route;
        undo_n++;
      end
      redo_n = 0;
    endfunction

    function void accept_frame(rtr_pkg::in_t item);
      route_t           old;
      route_t           tmp;
      rtr_pkg::sample_t smp [4];
      logic             lnk [4];
      int               p;
      rtr_pkg::out_t    want;
      old = route;
      smp = '{item.sample_in_a, item.sample_in_b, item.sample_in_c, item.sample_in_d};
      lnk = '{item.linked_a, item.linked_b, item.linked_c, item.linked_d};
      if (item.operation >= rtr_pkg::OP_ROT_DOWN && item.operation <= rtr_pkg::OP_RANDOM) begin
        save_edit();
      end
      case (item.operation)
        rtr_pkg::OP_ROT_DOWN: for (int k = 0; k < 4; k++) route[k] = old[(k + 1) % 4];
        rtr_pkg::OP_ROT_UP:   for (int k = 0; k < 4; k++) route[k] = old[(k + 3) % 4];
        rtr_pkg::OP_RESET:    route = route_t'(rtr_pkg::IDENTITY_MAP);
        rtr_pkg::OP_SWAP_AB:  route = swap_outputs(old, 0, 1);
        rtr_pkg::OP_SWAP_CD:  route = swap_outputs(old, 2, 3);
        rtr_pkg::OP_SWAP_BC:  route = swap_outputs(old, 1, 2);
        rtr_pkg::OP_SWAP_AD:  route = swap_outputs(old, 0, 3);
        rtr_pkg::OP_SWAP_AC:  route = swap_outputs(old, 0, 2);
        rtr_pkg::OP_SWAP_BD:  route = swap_outputs(old, 1, 3);
        rtr_pkg::OP_RANDOM:   route = load_perm(item.random_pick);
        rtr_pkg::OP_UNDO: begin
          if (undo_n > 0) begin
            p = (base + undo_n - 1) % rtr_pkg::HISTORY_DEPTH;
            tmp = history[p];
            history[p] = route;
            route = tmp;
            undo_n--;
            redo_n++;
          end
        end
        rtr_pkg::OP_REDO: begin
          if (redo_n > 0) begin
            p = (base + undo_n) % rtr_pkg::HISTORY_DEPTH;
            tmp = history[p];
            history[p] = route;
            route = tmp;
            undo_n++;
            redo_n--;
          end
        end
        default: ;
      endcase
      for (int k = 0; k < 4; k++) begin
        if (lnk[route[k]]) held[k] = smp[route[k]];
      end
      want.sample_out_a = held[0];
      want.sample_out_b = held[1];
      want.sample_out_c = held[2];
      want.sample_out_d = held[3];
      want.source_of_a  = route[0];
      want.source_of_b  = route[1];
      want.source_of_c  = route[2];
      want.source_of_d  = route[3];
      want.undo_depth   = rtr_pkg::DEPTH_BITS'(undo_n);
      want.redo_depth   = rtr_pkg::DEPTH_BITS'(redo_n);
      frames_due = {frames_due, want};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s expected %0h got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(rtr_pkg::out_t got);
      rtr_pkg::out_t want;
      if (frames_due.size() == 0) begin
        $error("result frame %h with nothing expected", got);
        errors++;
        return;
      end
      want = frames_due[0];
      frames_due.delete(0);
      check_field("sample_out_a", 32'(want.sample_out_a), 32'(got.sample_out_a));
      check_field("sample_out_b", 32'(want.sample_out_b), 32'(got.sample_out_b));
      check_field("sample_out_c", 32'(want.sample_out_c), 32'(got.sample_out_c));
      check_field("sample_out_d", 32'(want.sample_out_d), 32'(got.sample_out_d));
      check_field("source_of_a", 32'(want.source_of_a), 32'(got.source_of_a));
      check_field("source_of_b", 32'(want.source_of_b), 32'(got.source_of_b));
      check_field("source_of_c", 32'(want.source_of_c), 32'(got.source_of_c));
      check_field("source_of_d", 32'(want.source_of_d), 32'(got.source_of_d));
      check_field("undo_depth", 32'(want.undo_depth), 32'(got.undo_depth));
      check_field("redo_depth", 32'(want.redo_depth), 32'(got.redo_depth));
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  rtr_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  rtr_pkg::out_t out_data;

  route_tracker tracker = new();
  bit no_idle = 0;
  bit hold_request = 0;
  int cycles = 0;
  int sent = 0;

  four_way_router_with_undo_history dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_frame(out_data);
  end

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int stall;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 2) == 0) stall = idle_gap();
      end
    end
  end

  function automatic rtr_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return rtr_pkg::sample_t'(16'h8000);
    if (r == 1) return rtr_pkg::sample_t'(16'h7fff);
    if (r == 2) return '0;
    if (r == 3) return '1;
    return rtr_pkg::sample_t'($urandom);
  endfunction

  function automatic rtr_pkg::in_t make_frame(logic [rtr_pkg::OP_BITS-1:0] op);
    rtr_pkg::in_t f;
    f.operation   = op;
    f.random_pick = rtr_pkg::PICK_BITS'($urandom_range(0, 31));
    f.sample_in_a = pick_sample();
    f.sample_in_b = pick_sample();
    f.sample_in_c = pick_sample();
    f.sample_in_d = pick_sample();
    f.linked_a    = ($urandom_range(0, 3) != 0);
    f.linked_b    = ($urandom_range(0, 3) != 0);
    f.linked_c    = ($urandom_range(0, 3) != 0);
    f.linked_d    = ($urandom_range(0, 3) != 0);
    return f;
  endfunction

  function automatic logic [rtr_pkg::OP_BITS-1:0] some_edit();
    return rtr_pkg::OP_BITS'($urandom_range(rtr_pkg::OP_ROT_DOWN, rtr_pkg::OP_RANDOM));
  endfunction

  task automatic push_frame(rtr_pkg::in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    tracker.accept_frame(item);
    sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_op(logic [rtr_pkg::OP_BITS-1:0] op);
    push_frame(make_frame(op));
  endtask

  task automatic pause_until_drained();
    if (in_valid) in_valid <= 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rtr_pkg::in_t                  f;
    logic [rtr_pkg::PICK_BITS-1:0] picks [3];
    int                            n;
    int                            m;
    int                            kind;
    int                            deep_runs;
    int                            holds;
    int                            stop_at;
    picks     = '{5'd23, 5'd24, 5'd31};
    deep_runs = 0;
    holds     = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    f = make_frame(rtr_pkg::OP_NONE);
    f.sample_in_a = rtr_pkg::sample_t'(16'h7fff);
    f.sample_in_b = rtr_pkg::sample_t'(16'h8000);
    f.sample_in_c = '0;
    f.sample_in_d = '1;
    {f.linked_a, f.linked_b, f.linked_c, f.linked_d} = 4'b1111;
    push_frame(f);
    push_op(rtr_pkg::OP_UNDO);
    push_op(rtr_pkg::OP_REDO);
    f = make_frame(rtr_pkg::OP_SWAP_AB);
    {f.linked_a, f.linked_b, f.linked_c, f.linked_d} = 4'b0000;
    push_frame(f);
    for (int op = rtr_pkg::OP_ROT_DOWN; op <= rtr_pkg::OP_RANDOM; op++) begin
      push_op(rtr_pkg::OP_BITS'(op));
    end
    foreach (picks[i]) begin
      f = make_frame(rtr_pkg::OP_RANDOM);
      f.random_pick = picks[i];
      push_frame(f);
    end
    for (int op = rtr_pkg::OP_REDO + 1; op < 16; op++) push_op(rtr_pkg::OP_BITS'(op));
    push_op(rtr_pkg::OP_RESET);
    push_op(rtr_pkg::OP_RESET);
    push_op(rtr_pkg::OP_UNDO);
    push_op(rtr_pkg::OP_UNDO);
    push_op(rtr_pkg::OP_REDO);
    push_op(rtr_pkg::OP_REDO);
    push_op(rtr_pkg::OP_REDO);
    pause_until_drained();

    stop_at = sent + RANDOM_ITEMS;
    while (sent < stop_at) begin
      if ((holds == 0 && sent >= 600) || (holds == 1 && sent >= 1400)) begin
        hold_request = 1;
        holds++;
      end
      kind = $urandom_range(0, 99);
      if ((deep_runs == 0 && sent >= 900) ||
          (kind < 3 && deep_runs < 2 && sent + 4 * rtr_pkg::HISTORY_DEPTH < stop_at)) begin
        // fill the history past its depth, then walk it back and forth
        no_idle = (deep_runs == 0);
        n = rtr_pkg::HISTORY_DEPTH + $urandom_range(2, 20);
        repeat (n) push_op(some_edit());
        m = rtr_pkg::HISTORY_DEPTH + $urandom_range(0, 4);
        repeat (m) push_op(rtr_pkg::OP_UNDO);
        repeat (m) push_op(rtr_pkg::OP_REDO);
        no_idle = 0;
        deep_runs++;
      end else if (kind < 60) begin
        n = $urandom_range(1, 12);
        repeat (n) push_op(some_edit());
        m = $urandom_range(0, n + 2);
        repeat (m) push_op(rtr_pkg::OP_UNDO);
        m = $urandom_range(0, m + 2);
        repeat (m) push_op(rtr_pkg::OP_REDO);
      end else if (kind < 75) begin
        n = $urandom_range(5, 20);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: push_op(some_edit());
            1: push_op(rtr_pkg::OP_UNDO);
            default: push_op(rtr_pkg::OP_REDO);
          endcase
        end
      end else if (kind < 88) begin
        n = $urandom_range(3, 15);
        repeat (n) push_op(rtr_pkg::OP_BITS'($urandom_range(0, 15)));
      end else if (kind < 92) begin
        pause_until_drained();
      end else begin
        push_op(rtr_pkg::OP_BITS'($urandom_range(0, 15)));
      end
    end

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
